// ----- src/apss_pkg.sv -----
// apss_pkg: types, codes and constants of the ata pio sector sequencer
// no dependencies; used by the top level and its port checker
`timescale 1ns / 1ps

package apss_pkg;

    localparam int unsigned POLL_LIMIT       = 100000;
    localparam int unsigned WORDS_PER_SECTOR = 256;
    localparam int unsigned POLL_W           = $clog2(POLL_LIMIT + 1);
    localparam int unsigned WORD_W           = $clog2(WORDS_PER_SECTOR + 1);

    localparam int unsigned CFG_W    = 49;
    localparam int unsigned LBA_W    = 48;
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 24;

    // input kinds
    localparam logic [1:0] IN_CMD   = 2'd0;
    localparam logic [1:0] IN_REPLY = 2'd1;
    localparam logic [1:0] IN_WDATA = 2'd2;

    // host ops
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;
    localparam logic [1:0] OP_INVALID = 2'd3;

    // result kinds
    localparam logic [1:0] OK_BUS_WRITE = 2'd0;
    localparam logic [1:0] OK_BUS_READ  = 2'd1;
    localparam logic [1:0] OK_HOST_DATA = 2'd2;
    localparam logic [1:0] OK_DONE      = 2'd3;

    // completion codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DEVERR  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_REJECT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SLAVE   = 2'd0;
    localparam logic [1:0] CFG_LBA48   = 2'd1;
    localparam logic [1:0] CFG_SECTORS = 2'd2;
    localparam logic [1:0] CFG_PACKET  = 2'd3;

    // task-file offsets
    localparam logic [2:0] TF_DATA    = 3'd0;
    localparam logic [2:0] TF_SECCNT  = 3'd2;
    localparam logic [2:0] TF_LBA_LO  = 3'd3;
    localparam logic [2:0] TF_LBA_MID = 3'd4;
    localparam logic [2:0] TF_LBA_HI  = 3'd5;
    localparam logic [2:0] TF_DRIVE   = 3'd6;
    localparam logic [2:0] TF_CMD     = 3'd7;

    localparam logic [7:0] SEL28_SLAVE  = 8'hF0;
    localparam logic [7:0] SEL28_MASTER = 8'hE0;
    localparam logic [7:0] SEL48_SLAVE  = 8'h50;
    localparam logic [7:0] SEL48_MASTER = 8'h40;
    localparam logic [7:0] CMD_READ28   = 8'h20;
    localparam logic [7:0] CMD_READ48   = 8'h24;
    localparam logic [7:0] CMD_WRITE28  = 8'h30;
    localparam logic [7:0] CMD_WRITE48  = 8'h34;
    localparam logic [7:0] CMD_FLUSH28  = 8'hE7;
    localparam logic [7:0] CMD_FLUSH48  = 8'hEA;

    localparam logic [3:0] ISSUE28_LAST = 4'd10;
    localparam logic [3:0] ISSUE48_LAST = 4'd14;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_NB,
        PH_WAIT_DRQ,
        PH_READ_DATA,
        PH_WRITE_DATA,
        PH_FLUSH_WAIT
    } phase_t;

    // result sequences started by one accepted word
    typedef enum logic [3:0] {
        B_DONE,
        B_STATUS,
        B_DATA_READ,
        B_FLUSH,
        B_ISSUE,
        B_HOST_NEXT,
        B_HOST_DONE,
        B_WR_WORD,
        B_WR_DONE
    } burst_t;

endpackage

// ----- src/ata_pio_sector_sequencer.sv -----
// ata_pio_sector_sequencer: host-side ata pio engine, one sector per command
// depends on apss_pkg
//
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tuser kind, tdata op/lba/word
// m_*      out  tvalid/tready      tuser out_kind, tdata bus access, tlast
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// each accepted word updates the state and loads a result sequencer
// that emits 0 to 15 words, one per cycle while m_tready is high; the issue sequence is 11 words in lba28
// mode and 15 in lba48 mode, all other sequences are 1 or 2 words
// the next input word is taken in the cycle the last result of the previous one
// leaves, so single-result words flow at one per cycle while m_tready is high
// reset clears the phase, counters and config; a result word stalled by m_tready holds s_tready low
`timescale 1ns / 1ps

module ata_pio_sector_sequencer
    import apss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: op [1:0], lba [49:2], word [65:50], zero fill
    input  logic [S_DATA_W-1:0]   s_tdata,
    // s_tuser: kind [1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: reg_offset [2:0], control_block [3], wants_reply [4],
    //          bus_data [20:5], done_status [22:21], zero fill
    output logic [M_DATA_W-1:0]   m_tdata,
    // m_tuser: out_kind [1:0]
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    logic              slave_reg;
    logic              lba48_reg;
    logic [CFG_W-1:0]  sectors_reg;
    logic              packet_reg;

    phase_t            phase_reg, phase_next;
    logic [1:0]        saved_op_reg, saved_op_next;
    logic [LBA_W-1:0]  saved_lba_reg, saved_lba_next;
    logic [POLL_W-1:0] poll_count_reg, poll_count_next;
    logic [WORD_W-1:0] word_count_reg, word_count_next;

    logic              burst_active_reg;
    burst_t            burst_type_reg;
    logic [3:0]        burst_idx_reg;
    logic [15:0]       burst_word_reg;
    logic [1:0]        burst_status_reg;

    logic              start_burst;
    burst_t            new_type;
    logic [1:0]        new_status;

    logic [1:0]        in_kind;
    logic [1:0]        in_op;
    logic [LBA_W-1:0]  in_lba;
    logic [15:0]       in_word;
    logic [7:0]        stat;
    logic [POLL_W-1:0] poll_inc;
    logic              poll_hit;
    logic [WORD_W-1:0] word_inc;
    logic              word_hit;

    logic              s_fire;
    logic              m_fire;
    logic [3:0]        last_idx;
    logic              is_last;

    logic [1:0]        o_kind;
    logic [2:0]        o_reg;
    logic              o_ctl;
    logic              o_rep;
    logic [15:0]       o_data;
    logic [1:0]        o_status;

    assign in_kind = s_tuser;
    assign in_op   = s_tdata[1:0];
    assign in_lba  = s_tdata[49:2];
    assign in_word = s_tdata[65:50];
    assign stat    = in_word[7:0];

    assign poll_inc = poll_count_reg + POLL_W'(1);
    assign poll_hit = (poll_inc >= POLL_W'(POLL_LIMIT));
    assign word_inc = word_count_reg + WORD_W'(1);
    assign word_hit = (word_inc >= WORD_W'(WORDS_PER_SECTOR));

    assign s_tready = !burst_active_reg || (m_tready && is_last);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = burst_active_reg && m_tready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg   <= 1'b0;
            lba48_reg   <= 1'b0;
            sectors_reg <= '0;
            packet_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLAVE:   slave_reg   <= cfg_data[0];
                CFG_LBA48:   lba48_reg   <= cfg_data[0];
                CFG_SECTORS: sectors_reg <= cfg_data;
                CFG_PACKET:  packet_reg  <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // next state and the result sequence that the word starts
    always_comb
    begin
        phase_next      = phase_reg;
        saved_op_next   = saved_op_reg;
        saved_lba_next  = saved_lba_reg;
        poll_count_next = poll_count_reg;
        word_count_next = word_count_reg;
        start_burst     = 1'b0;
        new_type        = B_DONE;
        new_status      = ST_OK;

        unique case (phase_reg) inside
            PH_IDLE:
            begin
                if (in_kind == IN_CMD)
                begin
                    start_burst = 1'b1;
                    if (in_op == OP_INVALID || packet_reg)
                    begin
                        new_status      = ST_REJECT;
                        poll_count_next = '0;
                        word_count_next = '0;
                    end
                    else
                    begin
                        saved_op_next   = in_op;
                        saved_lba_next  = in_lba;
                        poll_count_next = '0;
                        word_count_next = '0;
                        if (in_op == OP_FLUSH)
                        begin
                            new_type   = B_FLUSH;
                            phase_next = PH_FLUSH_WAIT;
                        end
                        else if ({1'b0, in_lba} >= sectors_reg)
                        begin
                            new_status = ST_REJECT;
                        end
                        else
                        begin
                            new_type   = B_STATUS;
                            phase_next = PH_WAIT_NB;
                        end
                    end
                end
            end
            PH_WAIT_NB, PH_WAIT_DRQ, PH_FLUSH_WAIT:
            begin
                if (in_kind == IN_REPLY)
                begin
                    start_burst = 1'b1;
                    if (phase_reg == PH_WAIT_DRQ && stat[0])
                    begin
                        new_status      = ST_DEVERR;
                        phase_next      = PH_IDLE;
                        poll_count_next = '0;
                        word_count_next = '0;
                    end
                    else if (phase_reg == PH_WAIT_DRQ && !stat[7] && stat[3])
                    begin
                        poll_count_next = '0;
                        word_count_next = '0;
                        if (saved_op_reg == OP_WRITE)
                        begin
                            start_burst = 1'b0;
                            phase_next  = PH_WRITE_DATA;
                        end
                        else
                        begin
                            new_type   = B_DATA_READ;
                            phase_next = PH_READ_DATA;
                        end
                    end
                    else if (phase_reg == PH_WAIT_NB && !stat[7])
                    begin
                        new_type        = B_ISSUE;
                        phase_next      = PH_WAIT_DRQ;
                        poll_count_next = '0;
                    end
                    else if (phase_reg == PH_FLUSH_WAIT && !stat[7])
                    begin
                        new_status      = ST_OK;
                        phase_next      = PH_IDLE;
                        poll_count_next = '0;
                        word_count_next = '0;
                    end
                    else if (poll_hit)
                    begin
                        new_status      = ST_TIMEOUT;
                        phase_next      = PH_IDLE;
                        poll_count_next = '0;
                        word_count_next = '0;
                    end
                    else
                    begin
                        new_type        = B_STATUS;
                        poll_count_next = poll_inc;
                    end
                end
            end
            PH_READ_DATA:
            begin
                if (in_kind == IN_REPLY)
                begin
                    start_burst = 1'b1;
                    if (word_hit)
                    begin
                        new_type        = B_HOST_DONE;
                        phase_next      = PH_IDLE;
                        poll_count_next = '0;
                        word_count_next = '0;
                    end
                    else
                    begin
                        new_type        = B_HOST_NEXT;
                        word_count_next = word_inc;
                    end
                end
            end
            PH_WRITE_DATA:
            begin
                if (in_kind == IN_WDATA)
                begin
                    start_burst = 1'b1;
                    if (word_hit)
                    begin
                        new_type        = B_WR_DONE;
                        phase_next      = PH_IDLE;
                        poll_count_next = '0;
                        word_count_next = '0;
                    end
                    else
                    begin
                        new_type        = B_WR_WORD;
                        word_count_next = word_inc;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            saved_op_reg   <= '0;
            saved_lba_reg  <= '0;
            poll_count_reg <= '0;
            word_count_reg <= '0;
        end
        else if (s_fire)
        begin
            phase_reg      <= phase_next;
            saved_op_reg   <= saved_op_next;
            saved_lba_reg  <= saved_lba_next;
            poll_count_reg <= poll_count_next;
            word_count_reg <= word_count_next;
        end
    end

    // result sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_active_reg <= 1'b0;
            burst_idx_reg    <= '0;
        end
        else
        begin
            if (m_fire)
            begin
                if (is_last)
                    burst_active_reg <= 1'b0;
                else
                    burst_idx_reg <= burst_idx_reg + 4'd1;
            end
            if (s_fire && start_burst)
            begin
                burst_active_reg <= 1'b1;
                burst_idx_reg    <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_type_reg   <= B_DONE;
            burst_word_reg   <= '0;
            burst_status_reg <= ST_OK;
        end
        else if (s_fire && start_burst)
        begin
            burst_type_reg   <= new_type;
            burst_word_reg   <= in_word;
            burst_status_reg <= new_status;
        end
    end

    always_comb
    begin
        unique case (burst_type_reg) inside
            B_ISSUE:                                    last_idx = lba48_reg ? ISSUE48_LAST
                                                                             : ISSUE28_LAST;
            B_FLUSH, B_HOST_NEXT, B_HOST_DONE, B_WR_DONE: last_idx = 4'd1;
            default:                                    last_idx = 4'd0;
        endcase
    end

    assign is_last = (burst_idx_reg == last_idx);

    // decode of the current result word
    always_comb
    begin
        o_kind   = OK_BUS_WRITE;
        o_reg    = TF_DATA;
        o_ctl    = 1'b0;
        o_rep    = 1'b0;
        o_data   = '0;
        o_status = ST_OK;

        unique case (burst_type_reg) inside
            B_DONE:
            begin
                o_kind   = OK_DONE;
                o_status = burst_status_reg;
            end
            B_STATUS:
            begin
                o_kind = OK_BUS_READ;
                o_reg  = TF_CMD;
                o_rep  = 1'b1;
            end
            B_DATA_READ:
            begin
                o_kind = OK_BUS_READ;
                o_rep  = 1'b1;
            end
            B_FLUSH:
            begin
                if (burst_idx_reg == 4'd0)
                begin
                    o_reg  = TF_CMD;
                    o_data = {8'h00, lba48_reg ? CMD_FLUSH48 : CMD_FLUSH28};
                end
                else
                begin
                    o_kind = OK_BUS_READ;
                    o_reg  = TF_CMD;
                    o_rep  = 1'b1;
                end
            end
            B_HOST_NEXT, B_HOST_DONE:
            begin
                if (burst_idx_reg == 4'd0)
                begin
                    o_kind = OK_HOST_DATA;
                    o_data = burst_word_reg;
                end
                else if (burst_type_reg == B_HOST_NEXT)
                begin
                    o_kind = OK_BUS_READ;
                    o_rep  = 1'b1;
                end
                else
                begin
                    o_kind = OK_DONE;
                end
            end
            B_WR_WORD, B_WR_DONE:
            begin
                if (burst_idx_reg == 4'd0)
                    o_data = burst_word_reg;
                else
                    o_kind = OK_DONE;
            end
            B_ISSUE:
            begin
                if (burst_idx_reg == 4'd0)
                begin
                    o_reg = TF_DRIVE;
                    if (lba48_reg)
                        o_data = {8'h00, slave_reg ? SEL48_SLAVE : SEL48_MASTER};
                    else
                        o_data = {8'h00, (slave_reg ? SEL28_SLAVE : SEL28_MASTER)
                                         | {4'h0, saved_lba_reg[27:24]}};
                end
                else if (burst_idx_reg <= 4'd4)
                begin
                    // delay reads of alternate status
                    o_kind = OK_BUS_READ;
                    o_ctl  = 1'b1;
                end
                else if (burst_idx_reg == last_idx)
                begin
                    o_kind = OK_BUS_READ;
                    o_reg  = TF_CMD;
                    o_rep  = 1'b1;
                end
                else if (burst_idx_reg == last_idx - 4'd1)
                begin
                    o_reg = TF_CMD;
                    if (saved_op_reg == OP_WRITE)
                        o_data = {8'h00, lba48_reg ? CMD_WRITE48 : CMD_WRITE28};
                    else
                        o_data = {8'h00, lba48_reg ? CMD_READ48 : CMD_READ28};
                end
                else if (lba48_reg)
                begin
                    case (burst_idx_reg)
                        4'd5:    o_reg = TF_SECCNT;
                        4'd6:
                        begin
                            o_reg  = TF_LBA_LO;
                            o_data = {8'h00, saved_lba_reg[31:24]};
                        end
                        4'd7:
                        begin
                            o_reg  = TF_LBA_MID;
                            o_data = {8'h00, saved_lba_reg[39:32]};
                        end
                        4'd8:
                        begin
                            o_reg  = TF_LBA_HI;
                            o_data = {8'h00, saved_lba_reg[47:40]};
                        end
                        4'd9:
                        begin
                            o_reg  = TF_SECCNT;
                            o_data = 16'h0001;
                        end
                        4'd10:
                        begin
                            o_reg  = TF_LBA_LO;
                            o_data = {8'h00, saved_lba_reg[7:0]};
                        end
                        4'd11:
                        begin
                            o_reg  = TF_LBA_MID;
                            o_data = {8'h00, saved_lba_reg[15:8]};
                        end
                        default:
                        begin
                            o_reg  = TF_LBA_HI;
                            o_data = {8'h00, saved_lba_reg[23:16]};
                        end
                    endcase
                end
                else
                begin
                    case (burst_idx_reg)
                        4'd5:
                        begin
                            o_reg  = TF_SECCNT;
                            o_data = 16'h0001;
                        end
                        4'd6:
                        begin
                            o_reg  = TF_LBA_LO;
                            o_data = {8'h00, saved_lba_reg[7:0]};
                        end
                        4'd7:
                        begin
                            o_reg  = TF_LBA_MID;
                            o_data = {8'h00, saved_lba_reg[15:8]};
                        end
                        default:
                        begin
                            o_reg  = TF_LBA_HI;
                            o_data = {8'h00, saved_lba_reg[23:16]};
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = burst_active_reg;
    assign m_tuser  = o_kind;
    assign m_tlast  = is_last;
    assign m_tdata  = {1'b0, o_status, o_data, o_rep, o_ctl, o_reg};

endmodule

// ----- src/apss_checker.sv -----
// apss_checker: port-level checks for ata_pio_sector_sequencer, bound to the top level
// depends on apss_pkg
`timescale 1ns / 1ps

module apss_checker
    import apss_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [1:0]          m_tuser,
    input logic                m_tlast
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result word changed");

    // a completion ends the sequence of its input word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == OK_DONE |-> m_tlast)
        else $error("completion without tlast");

    // control-block accesses are only delay reads
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tuser == OK_BUS_READ && !m_tdata[4])
        else $error("control-block access that is not a delay read");

    // no new input word while a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

bind ata_pio_sector_sequencer apss_checker u_apss_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
